// ===== hdl/bdp_pkg.sv =====
// bdp_pkg: shared types and constants for the button datagram parser.
// No dependencies.
package bdp_pkg;

    localparam int unsigned PktLen    = 36;
    localparam int unsigned CountW    = 6;
    localparam int unsigned NumBits   = 16;
    localparam int unsigned BitIdxW   = 4;
    localparam logic [7:0]  VERSION   = 8'h01;
    localparam logic [7:0]  FULL_MASK = 8'h02;
    // bits 0..3 never produce events
    localparam logic [15:0] EVENT_MASK = 16'hFFF0;

    localparam logic [7:0] MAGIC [4] = '{8'h42, 8'h4D, 8'h49, 8'h52};

    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // one finished datagram, handed from the parser to the event emitter
    typedef struct packed {
        logic        valid;
        logic        ok;
        logic [15:0] pressed;
        logic [15:0] released;
        logic [15:0] held;
    } t_job;

endpackage

// ===== hdl/bdp_parser.sv =====
// bdp_parser: byte-serial header check and word capture, held button update.
// Depends on bdp_pkg.
module bdp_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_data_byte,
    input  logic          i_end_of_datagram,
    output bdp_pkg::t_job o_job
);
    import bdp_pkg::*;

    logic [CountW-1:0] r_count, n_count;
    logic              r_hok, n_hok;
    logic              r_full, n_full;
    logic [15:0]       r_after, n_after;
    logic [15:0]       r_pr, n_pr;
    logic [15:0]       r_rl, n_rl;
    logic [15:0]       r_held, n_held;
    t_job              job;

    always_comb begin
        n_count = r_count;
        n_hok   = r_hok;
        n_full  = r_full;
        n_after = r_after;
        n_pr    = r_pr;
        n_rl    = r_rl;
        n_held  = r_held;
        job     = '0;
        if (i_accept && (r_count < CountW'(PktLen))) begin
            if (r_count inside {[0:3]}) begin
                if (i_data_byte != MAGIC[r_count[1:0]]) begin
                    n_hok = 1'b0;
                end
            end else begin
                case (r_count)
                    6'd4: begin
                        if (i_data_byte != VERSION) begin
                            n_hok = 1'b0;
                        end
                    end
                    6'd5:  n_full = (i_data_byte & FULL_MASK) != 8'h00;
                    6'd30: n_after[15:8] = i_data_byte;
                    6'd31: n_after[7:0]  = i_data_byte;
                    6'd32: n_pr[15:8]    = i_data_byte;
                    6'd33: n_pr[7:0]     = i_data_byte;
                    6'd34: n_rl[15:8]    = i_data_byte;
                    6'd35: n_rl[7:0]     = i_data_byte;
                    default: ;
                endcase
            end
            n_count = r_count + CountW'(1);
        end
        if (i_accept && i_end_of_datagram) begin
            job.valid = 1'b1;
            job.ok    = (n_count >= CountW'(PktLen)) && n_hok;
            if (job.ok) begin
                if (n_full) begin
                    job.pressed  = n_after & ~r_held;
                    job.released = r_held & ~n_after;
                    n_held       = n_after;
                end else begin
                    job.pressed  = n_pr;
                    job.released = n_rl;
                    n_held       = (r_held | n_pr) & ~n_rl;
                end
            end
            job.pressed  = job.pressed & EVENT_MASK;
            job.released = job.released & EVENT_MASK;
            job.held     = n_held;
            n_count = '0;
            n_hok   = 1'b1;
            n_full  = 1'b0;
            n_after = '0;
            n_pr    = '0;
            n_rl    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_hok   <= 1'b1;
            r_full  <= 1'b0;
            r_after <= '0;
            r_pr    <= '0;
            r_rl    <= '0;
            r_held  <= '0;
        end else begin
            r_count <= n_count;
            r_hok   <= n_hok;
            r_full  <= n_full;
            r_after <= n_after;
            r_pr    <= n_pr;
            r_rl    <= n_rl;
            r_held  <= n_held;
        end
    end

    assign o_job = job;

endmodule

// ===== hdl/bdp_emitter.sv =====
// bdp_emitter: walks a finished datagram's edge masks, one item per cycle,
// unless stalled, into the output register. Depends on bdp_pkg.
module bdp_emitter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bdp_pkg::t_job   i_job,
    output logic            o_busy,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [1:0]      o_event_kind,
    output logic [3:0]      o_button_bit,
    output logic            o_accepted,
    output logic [15:0]     o_button_state,
    output logic            o_last_of_run
);
    import bdp_pkg::*;

    logic               r_busy;
    logic               r_ok;
    logic [15:0]        r_pr;
    logic [15:0]        r_rl;
    logic [15:0]        r_held;
    logic               r_ovalid;
    logic [1:0]         r_kind;
    logic [BitIdxW-1:0] r_bit;
    logic               r_acc;
    logic [15:0]        r_state;
    logic               r_last;

    logic [15:0]        pend;
    logic [BitIdxW-1:0] low_bit;
    logic               out_load;
    logic               advance;

    // lowest pending bit
    always_comb begin
        low_bit = '0;
        for (int k = NumBits - 1; k >= 0; k--) begin
            if (pend[k]) begin
                low_bit = BitIdxW'(k);
            end
        end
    end

    assign pend     = r_pr | r_rl;
    assign out_load = !r_ovalid || !i_stall;
    assign advance  = r_busy && out_load;
    // a new job may enter in the cycle the status item loads
    assign o_busy   = r_busy && !(advance && (pend == '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (advance) begin
                r_ovalid <= 1'b1;
                r_state  <= r_held;
                if (pend == '0) begin
                    r_kind <= KIND_STATUS;
                    r_bit  <= '0;
                    r_acc  <= r_ok;
                    r_last <= 1'b1;
                end else if (r_pr[low_bit]) begin
                    r_kind         <= KIND_PRESS;
                    r_bit          <= low_bit;
                    r_acc          <= 1'b1;
                    r_last         <= 1'b0;
                    r_pr[low_bit]  <= 1'b0;
                end else begin
                    r_kind         <= KIND_RELEASE;
                    r_bit          <= low_bit;
                    r_acc          <= 1'b1;
                    r_last         <= 1'b0;
                    r_rl[low_bit]  <= 1'b0;
                end
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_job.valid) begin
                r_busy <= 1'b1;
                r_ok   <= i_job.ok;
                r_pr   <= i_job.pressed;
                r_rl   <= i_job.released;
                r_held <= i_job.held;
            end else if (advance && (pend == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_valid        = r_ovalid;
    assign o_event_kind   = r_kind;
    assign o_button_bit   = r_bit;
    assign o_accepted     = r_acc;
    assign o_button_state = r_state;
    assign o_last_of_run  = r_last;

endmodule

// ===== hdl/button_datagram_parser.sv =====
// button_datagram_parser: top level, parser followed by event emitter.
// Depends on bdp_pkg, bdp_parser, bdp_emitter.
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------------
//  input    | i_valid / o_stall   | i_data_byte, i_end_of_datagram
//  output   | o_valid / i_stall   | o_event_kind, o_button_bit, o_accepted,
//           |                     | o_button_state, o_last_of_run
//
// One byte transfer per cycle while not stalled. Each byte is absorbed in the
// cycle it arrives; the last byte of a datagram hands a job (edge masks, new
// held state) to the emitter in the same cycle.
// The emitter puts out one item per cycle while the output is not stalled:
// the events of the datagram, then its status item, so a datagram gives
// 1 + (number of events) items, at most 25. The input stalls, whatever the
// byte, while the emitter still holds an earlier job, and output stall
// prolongs this; a byte transfers again in the cycle the status item loads.
// Output stall holds the output register; a new item loads when it empties.
// Reset (synchronous, i_rst_n low) clears parser state, the held buttons and
// the emitter's busy and output valid flags.
module button_datagram_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_datagram,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_event_kind,
    output logic [3:0]  o_button_bit,
    output logic        o_accepted,
    output logic [15:0] o_button_state,
    output logic        o_last_of_run
);
    import bdp_pkg::*;

    t_job job;
    logic busy;
    logic accept;

    // the emitter has a single job slot; stall all input while it is taken
    assign o_stall = busy;
    assign accept  = i_valid && !busy;

    bdp_parser u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_data_byte       (i_data_byte),
        .i_end_of_datagram (i_end_of_datagram),
        .o_job             (job)
    );

    bdp_emitter u_emitter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (job),
        .o_busy         (busy),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_event_kind   (o_event_kind),
        .o_button_bit   (o_button_bit),
        .o_accepted     (o_accepted),
        .o_button_state (o_button_state),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

// ===== hdl/bdp_checker.sv =====
// bdp_checker: port-level assertions for button_datagram_parser, bound in.
// Depends on bdp_pkg.
module bdp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [7:0]  i_data_byte,
    input logic        i_end_of_datagram,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_event_kind,
    input logic [3:0]  o_button_bit,
    input logic        o_accepted,
    input logic [15:0] o_button_state,
    input logic        o_last_of_run
);
    import bdp_pkg::*;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_data_byte)
            && $stable(i_end_of_datagram))
        else $error("stalled input changed");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_event_kind)
            && $stable(o_button_bit) && $stable(o_button_state)
            && $stable(o_last_of_run) && $stable(o_accepted))
        else $error("stalled output changed");

    a_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_kind != KIND_STATUS)
            |-> !o_last_of_run && o_accepted && (o_button_bit >= 4'd4))
        else $error("bad event item");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_kind == KIND_STATUS)
            |-> o_last_of_run && (o_button_bit == 4'd0))
        else $error("bad status item");

    a_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_of_run
            |=> !o_valid || (o_button_state == $past(o_button_state)))
        else $error("button state changed inside a run");

endmodule

bind button_datagram_parser bdp_checker u_bdp_checker (.*);

// ===== tb/tb_button_datagram_parser.sv =====
// tb_button_datagram_parser: self-checking testbench for button_datagram_parser.
// Depends on bdp_pkg and the button_datagram_parser RTL. Runs a directed table of
// datagrams, then random ones. Every result is checked against an in-bench predictor.
module tb_button_datagram_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import bdp_pkg::*;

    localparam int unsigned CLK_HALF     = 4;
    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned IDLE_PCT     = 6;
    localparam int unsigned RAND_BYTES   = 60;
    localparam int unsigned RAND_DGRAMS  = 2;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned HOLD_AFTER   = 20;    // results seen before the long hold-off
    localparam int unsigned MAX_SHOWN    = 10;
    localparam int unsigned DRAIN_LIMIT  = 100000;
    localparam int unsigned TAIL_CYCLES  = 40;    // > worst burst of 25 items per datagram
    localparam int unsigned NUM_ROWS     = 6;
    localparam logic [7:0]  NO_CORRUPT   = 8'hFF;

    // sender and receiver quiet windows: no random idling inside them
    localparam int unsigned TX_QUIET_LO = 20;
    localparam int unsigned TX_QUIET_HI = 120;
    localparam int unsigned RX_QUIET_LO = 20;
    localparam int unsigned RX_QUIET_HI = 120;

    // one byte transfer on the input channel
    typedef struct packed {
        logic [7:0] data;
        logic       eod;
    } t_rx_byte;

    // one result transfer on the output channel
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  btn;
        logic        acc;
        logic [15:0] state;
        logic        last;
    } t_btn_item;

    // status of a datagram typed in by hand, or left to the predictor
    typedef struct packed {
        logic        by_hand;
        logic        acc;
        logic [15:0] state;
    } t_status_note;

    // one row of the directed table: how to build a datagram
    typedef struct packed {
        logic [7:0]  len;
        logic [7:0]  bad_pos;
        logic [7:0]  bad_val;
        logic [7:0]  version;
        logic [7:0]  flags;
        logic [15:0] after_v;
        logic [15:0] press_v;
        logic [15:0] release_v;
        logic        by_hand;
        logic        t_acc;
        logic [15:0] t_state;
    } t_dgram_row;

    // DUT ports; every input has a known value from time zero
    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_valid           = 1'b0;
    logic [7:0]  i_data_byte       = 8'h00;
    logic        i_end_of_datagram = 1'b0;
    logic        i_stall           = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_event_kind;
    logic [3:0]  o_button_bit;
    logic        o_accepted;
    logic [15:0] o_button_state;
    logic        o_last_of_run;

    // stimulus store, filled before reset is released
    t_rx_byte     byte_stream [$];
    t_status_note status_notes [$];
    t_dgram_row   directed_rows [NUM_ROWS];
    int unsigned  send_idx    = 0;
    int unsigned  bytes_taken = 0;

    // predictor state: per-datagram parse state plus the held buttons
    logic [5:0]  frame_pos;
    logic        hdr_good;
    logic        full_mode;
    logic [15:0] after_w;
    logic [15:0] press_w;
    logic [15:0] release_w;
    logic [15:0] held_now;
    t_btn_item   pending_items [$];

    int unsigned failures     = 0;
    int unsigned results_seen = 0;

    // receiver hold-off bookkeeping
    int unsigned rx_cycle  = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    button_datagram_parser dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_data_byte       (i_data_byte),
        .i_end_of_datagram (i_end_of_datagram),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_event_kind      (o_event_kind),
        .o_button_bit      (o_button_bit),
        .o_accepted        (o_accepted),
        .o_button_state    (o_button_state),
        .o_last_of_run     (o_last_of_run)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    // word pattern: all clear, all set, sparse or dense random
    function automatic logic [15:0] rand_word();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom) & 16'($urandom);
            default: return 16'($urandom);
        endcase
    endfunction

    // Lays out one datagram byte by byte: magic, version, flags, random
    // timestamp/session filler, the three big-endian words, then random
    // trailing bytes. Truncated at len, with the end mark on the last byte.
    // One byte may be overwritten to break the header; noise makes every
    // byte random.
    task automatic queue_datagram(input int unsigned len, input logic noise,
                                  input logic [7:0] bad_pos, input logic [7:0] bad_val,
                                  input logic [7:0] version, input logic [7:0] flags,
                                  input logic [15:0] after_v, input logic [15:0] press_v,
                                  input logic [15:0] release_v, input t_status_note note);
        logic [7:0] b;
        t_rx_byte   item;
        for (int unsigned p = 0; p < len; p++) begin
            case (p)
                0, 1, 2, 3: b = MAGIC[p[1:0]];
                4:          b = version;
                5:          b = flags;
                30:         b = after_v[15:8];
                31:         b = after_v[7:0];
                32:         b = press_v[15:8];
                33:         b = press_v[7:0];
                34:         b = release_v[15:8];
                35:         b = release_v[7:0];
                default:    b = 8'($urandom);
            endcase
            if (noise)
                b = 8'($urandom);
            if (p == int'(bad_pos))
                b = bad_val;
            item.data = b;
            item.eod  = (p == len - 1);
            byte_stream.push_back(item);
        end
        status_notes.push_back(note);
    endtask

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    task automatic clear_frame();
        frame_pos = '0;
        hdr_good  = 1'b1;
        full_mode = 1'b0;
        after_w   = '0;
        press_w   = '0;
        release_w = '0;
    endtask

    // position counter stops at the packet length, so trailing bytes do nothing
    task automatic absorb_byte(input logic [7:0] b);
        if (frame_pos < PktLen) begin
            case (frame_pos)
                0, 1, 2, 3: if (b != MAGIC[frame_pos[1:0]]) hdr_good = 1'b0;
                4:          if (b != VERSION) hdr_good = 1'b0;
                5:          full_mode = (b & FULL_MASK) != 8'h00;
                30:         after_w[15:8]   = b;
                31:         after_w[7:0]    = b;
                32:         press_w[15:8]   = b;
                33:         press_w[7:0]    = b;
                34:         release_w[15:8] = b;
                35:         release_w[7:0]  = b;
                default:    ;
            endcase
            frame_pos = frame_pos + 6'd1;
        end
    endtask

    // end mark: apply the datagram, queue its events in bit order, then status
    task automatic finish_datagram();
        logic         ok;
        logic [15:0]  pr;
        logic [15:0]  rl;
        t_status_note note;
        t_btn_item    item;
        ok = (frame_pos >= PktLen) && hdr_good;
        if (ok) begin
            if (full_mode) begin
                // edges come from the old held vector
                pr       = after_w & ~held_now;
                rl       = held_now & ~after_w;
                held_now = after_w;
            end else begin
                pr       = press_w;
                rl       = release_w;
                held_now = (held_now | pr) & ~rl;
            end
            for (int n = 0; n < NumBits; n++) begin
                if (EVENT_MASK[n] && pr[n]) begin
                    item = '{KIND_PRESS, 4'(n), 1'b1, held_now, 1'b0};
                    pending_items.push_back(item);
                end
                if (EVENT_MASK[n] && rl[n]) begin
                    item = '{KIND_RELEASE, 4'(n), 1'b1, held_now, 1'b0};
                    pending_items.push_back(item);
                end
            end
        end
        note = status_notes.pop_front();
        if (note.by_hand)
            item = '{KIND_STATUS, 4'd0, note.acc, note.state, 1'b1};
        else
            item = '{KIND_STATUS, 4'd0, ok, held_now, 1'b1};
        pending_items.push_back(item);
        clear_frame();
    endtask

    task automatic log_failure(input string why, input t_btn_item want, input t_btn_item got);
        failures++;
        if (failures <= MAX_SHOWN)
            $display({"%0t %s: exp kind=%0d bit=%0d acc=%0b state=%h last=%0b",
                      " | got kind=%0d bit=%0d acc=%0b state=%h last=%0b"},
                     $time, why, want.kind, want.btn, want.acc, want.state, want.last,
                     got.kind, got.btn, got.acc, got.state, got.last);
    endtask

    // ------------------------------------------------------------------
    // Sender: offers bytes, holds the payload while stalled, idles at random
    // outside its quiet window.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : tx_proc
        logic gap;
        if (i_rst_n && (!i_valid || !o_stall)) begin
            gap = !(send_idx >= TX_QUIET_LO && send_idx < TX_QUIET_HI)
                  && ($urandom_range(99) < IDLE_PCT);
            if (send_idx < byte_stream.size() && !gap) begin
                i_data_byte       <= byte_stream[send_idx].data;
                i_end_of_datagram <= byte_stream[send_idx].eod;
                i_valid           <= 1'b1;
                send_idx++;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, a quiet window, and one long hold-off while
    // the sender keeps going so the block backs up into its input.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : rx_proc
        if (i_rst_n) begin
            rx_cycle <= rx_cycle + 1;
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_stall   <= 1'b1;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                i_stall   <= 1'b1;
            end else if (rx_cycle >= RX_QUIET_LO && rx_cycle < RX_QUIET_HI) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks output transfers against the oldest expectation, then
    // feeds accepted input transfers to the predictor. Both sides sample the
    // values present at the clock edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : mon_proc
        t_btn_item got;
        t_btn_item want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = '{o_event_kind, o_button_bit, o_accepted, o_button_state, o_last_of_run};
                results_seen++;
                if (pending_items.size() == 0) begin
                    log_failure("result with nothing expected", '0, got);
                end else begin
                    want = pending_items.pop_front();
                    if (got.kind !== want.kind || got.btn !== want.btn
                        || got.acc !== want.acc || got.state !== want.state
                        || got.last !== want.last)
                        log_failure("mismatch", want, got);
                end
            end
            if (i_valid && !o_stall) begin
                bytes_taken++;
                absorb_byte(i_data_byte);
                if (i_end_of_datagram)
                    finish_datagram();
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_proc
        int unsigned  base;
        int unsigned  rand_dgrams;
        int unsigned  sel;
        int unsigned  waited;
        t_status_note by_model;
        by_model = '{1'b0, 1'b0, 16'h0000};
        clear_frame();
        held_now = '0;

        // Directed datagrams. The first four are all rejected while the held
        // vector is still clear, so their status is typed in: a lone byte,
        // one byte short, broken magic, wrong version. The rest go through
        // the predictor: press and release on every bit (the longest burst),
        // then a full-state change with trailing bytes that run well past the
        // packet length, where the byte counter stops.
        directed_rows = '{
            '{8'd1,  NO_CORRUPT, 8'h00, VERSION, 8'h00, 16'h0000, 16'h0000, 16'h0000,
              1'b1, 1'b0, 16'h0000},
            '{8'd35, NO_CORRUPT, 8'h00, VERSION, 8'h02, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              1'b1, 1'b0, 16'h0000},
            '{8'd36, 8'd1,       8'hB2, VERSION, 8'h02, 16'hFFFF, 16'h0000, 16'h0000,
              1'b1, 1'b0, 16'h0000},
            '{8'd36, NO_CORRUPT, 8'h00, 8'h00,   8'h00, 16'h0000, 16'hFFFF, 16'h0000,
              1'b1, 1'b0, 16'h0000},
            '{8'd36, NO_CORRUPT, 8'h00, VERSION, 8'hFD, 16'h0000, 16'hFFFF, 16'hFFFF,
              1'b0, 1'b0, 16'h0000},
            '{8'd72, NO_CORRUPT, 8'h00, VERSION, 8'h02, 16'hA5A5, 16'h1234, 16'h8001,
              1'b0, 1'b0, 16'h0000}
        };
        foreach (directed_rows[r])
            queue_datagram(int'(directed_rows[r].len), 1'b0, directed_rows[r].bad_pos,
                           directed_rows[r].bad_val, directed_rows[r].version,
                           directed_rows[r].flags, directed_rows[r].after_v,
                           directed_rows[r].press_v, directed_rows[r].release_v,
                           '{directed_rows[r].by_hand, directed_rows[r].t_acc,
                             directed_rows[r].t_state});

        // Random datagrams: mostly well formed with random flags and words,
        // the rest short, header-damaged or pure noise.
        base        = byte_stream.size();
        rand_dgrams = 0;
        while (byte_stream.size() - base < RAND_BYTES || rand_dgrams < RAND_DGRAMS) begin
            sel = $urandom_range(99);
            if (sel < 70)
                queue_datagram((sel < 55) ? 36 : $urandom_range(72, 37), 1'b0, NO_CORRUPT,
                               8'h00, VERSION, 8'($urandom), rand_word(), rand_word(),
                               rand_word(), by_model);
            else if (sel < 82)
                queue_datagram($urandom_range(35, 1), 1'b0, NO_CORRUPT, 8'h00, VERSION,
                               8'($urandom), rand_word(), rand_word(), rand_word(), by_model);
            else if (sel < 94)
                queue_datagram($urandom_range(40, 36), 1'b0, 8'($urandom_range(4)),
                               8'($urandom), VERSION, 8'($urandom), rand_word(),
                               rand_word(), rand_word(), by_model);
            else
                queue_datagram($urandom_range(45, 1), 1'b1, NO_CORRUPT, 8'h00, VERSION,
                               8'h00, 16'h0000, 16'h0000, 16'h0000, by_model);
            rand_dgrams++;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every byte transferred, then drain the expected results
        while (bytes_taken < byte_stream.size())
            @(posedge i_clk);
        waited = 0;
        while (pending_items.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        // extra cycles to catch anything the block puts out beyond the prediction
        repeat (TAIL_CYCLES) @(posedge i_clk);
        failures += pending_items.size();

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin : watchdog_proc
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
